[hw/rtl/sync_length_packet_deframer_assert.svh]
// Assertion macros shared by the deframer RTL.
`ifndef SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH
`define SYNC_LENGTH_PACKET_DEFRAMER_ASSERT_SVH

// Same-cycle implication, checked at every clock edge outside reset.
`define SLPD_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every clock edge outside reset.
`define SLPD_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/slpd_pkg.sv]
// Types and constants of the sync/length packet deframer.
package slpd_pkg;

  localparam int BYTE_W   = 8;
  localparam int POS_W    = 10;
  localparam int LEN_W    = 16;
  localparam int MAXLEN_W = 10;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_VALUE = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_LENGTH = 1'd1;

  // Reset values of the registers
  localparam logic [BYTE_W-1:0]   SYNC_VALUE_RESET = 8'h61;
  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RESET = 10'h144;

  // Ceiling on the clamp so counts and positions stay in 10 bits
  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_CEILING = 10'd1019;
  localparam logic [POS_W-1:0]    FIRST_DATA_POSITION = 10'd3;

  // Parser phases
  localparam int PHASE_W = 2;
  localparam logic [PHASE_W-1:0] PHASE_HUNT     = 2'd0;
  localparam logic [PHASE_W-1:0] PHASE_LEN_HIGH = 2'd1;
  localparam logic [PHASE_W-1:0] PHASE_LEN_LOW  = 2'd2;
  localparam logic [PHASE_W-1:0] PHASE_DATA     = 2'd3;

  // One result item
  typedef struct packed {
    logic [BYTE_W-1:0] packet_byte;
    logic [POS_W-1:0]  position;
    logic              last_of_packet;
    logic [LEN_W-1:0]  declared_length;
  } result_t;

endpackage

[hw/rtl/sync_length_packet_deframer.sv]
// Sync/length packet deframer: hunts for a sync byte, parses the length, tags packet bytes.
//
// Takes one received byte per cycle unless stalled. While hunting, bytes that do not match
// sync_value are dropped. A match starts a packet: the next two bytes are a
// big-endian declared length, which is clamped to max_length (itself capped at
// 1019) and gives length+1 further bytes (type byte and payload). Every packet
// byte is passed on with its position (sync is 0); the final byte is flagged
// last_of_packet and carries the unclamped declared length. Each accepted byte
// is parsed in the cycle it is accepted and its result is registered in the output
// register, or in the skid register when that is blocked; one byte per cycle is sustained
// while out_stall is low. A one-entry skid register behind the output register absorbs
// a stalled result, so in_stall rises only when both are full. max_length writes take
// effect at the next length header, sync_value writes at once; no clearing pass after reset.
`include "sync_length_packet_deframer_assert.svh"

module sync_length_packet_deframer (
  input  logic                           clk,
  input  logic                           rst,
  // configuration write port
  input  logic                           cfg_write,
  input  logic [slpd_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [slpd_pkg::CFG_W-1:0]     cfg_data,
  // received byte channel
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [slpd_pkg::BYTE_W-1:0]    rx_byte,
  // packet byte channel
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [slpd_pkg::BYTE_W-1:0]    packet_byte,
  output logic [slpd_pkg::POS_W-1:0]     position,
  output logic                           last_of_packet,
  output logic [slpd_pkg::LEN_W-1:0]     declared_length
);
  import slpd_pkg::*;

  // configuration registers
  logic [BYTE_W-1:0]   sync_value;
  logic [MAXLEN_W-1:0] max_length;

  // parser state
  logic [PHASE_W-1:0] phase;
  logic [PHASE_W-1:0] phase_next;
  logic [POS_W-1:0]   bytes_left;
  logic [POS_W-1:0]   bytes_left_next;
  logic [POS_W-1:0]   write_position;
  logic [POS_W-1:0]   write_position_next;
  logic [BYTE_W-1:0]  length_high_byte;
  logic [BYTE_W-1:0]  length_low_byte;

  // output and skid registers
  result_t out_reg;
  result_t skid_reg;
  logic    skid_valid;

  // combinational result of the byte being accepted
  result_t             res;
  logic                res_valid;
  logic                accept;
  logic                take_out;
  logic                out_free;
  logic [LEN_W-1:0]    header_length;
  logic [MAXLEN_W-1:0] limit;
  logic [MAXLEN_W-1:0] clamped;

  assign in_stall = skid_valid;
  assign accept   = in_valid && !skid_valid;
  assign take_out = out_valid && !out_stall;
  assign out_free = !out_valid || take_out;

  // clamp the declared length against the capped maximum
  assign header_length = {length_high_byte, rx_byte};
  assign limit   = (max_length > MAX_LENGTH_CEILING) ? MAX_LENGTH_CEILING : max_length;
  assign clamped = (header_length > LEN_W'(limit)) ? limit : header_length[MAXLEN_W-1:0];

  // parse one byte
  always_comb begin
    phase_next          = phase;
    bytes_left_next     = bytes_left;
    write_position_next = write_position;
    res_valid           = 1'b0;
    res.packet_byte     = rx_byte;
    res.position        = '0;
    res.last_of_packet  = 1'b0;
    res.declared_length = '0;
    unique case (phase)
      PHASE_HUNT: begin
        if (rx_byte == sync_value) begin
          res_valid  = accept;
          phase_next = PHASE_LEN_HIGH;
        end
      end
      PHASE_LEN_HIGH: begin
        res_valid    = accept;
        res.position = POS_W'(1);
        phase_next   = PHASE_LEN_LOW;
      end
      PHASE_LEN_LOW: begin
        res_valid           = accept;
        res.position        = POS_W'(2);
        bytes_left_next     = clamped + POS_W'(1);
        write_position_next = FIRST_DATA_POSITION;
        phase_next          = PHASE_DATA;
      end
      PHASE_DATA: begin
        res_valid           = accept;
        res.position        = write_position;
        write_position_next = write_position + POS_W'(1);
        bytes_left_next     = bytes_left - POS_W'(1);
        if (bytes_left == POS_W'(1)) begin
          res.last_of_packet  = 1'b1;
          res.declared_length = {length_high_byte, length_low_byte};
          phase_next          = PHASE_HUNT;
        end
      end
      default: begin
        phase_next = PHASE_HUNT;
      end
    endcase
  end

  // write configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      sync_value <= SYNC_VALUE_RESET;
      max_length <= MAX_LENGTH_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_SYNC_VALUE: sync_value <= cfg_data[BYTE_W-1:0];
        REG_MAX_LENGTH: max_length <= cfg_data[MAXLEN_W-1:0];
        default: ;
      endcase
    end
  end

  // advance parser state on each accepted byte
  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PHASE_HUNT;
      bytes_left       <= '0;
      write_position   <= '0;
      length_high_byte <= '0;
      length_low_byte  <= '0;
    end else if (accept) begin
      phase          <= phase_next;
      bytes_left     <= bytes_left_next;
      write_position <= write_position_next;
      if (phase == PHASE_LEN_HIGH) begin
        length_high_byte <= rx_byte;
      end
      if (phase == PHASE_LEN_LOW) begin
        length_low_byte <= rx_byte;
      end
    end
  end

  // hold results in the output register, spill into skid when it is blocked
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else begin
      if (out_free) begin
        out_valid <= skid_valid || res_valid;
      end
      if (skid_valid && out_free) begin
        skid_valid <= 1'b0;
      end else if (res_valid && !out_free) begin
        skid_valid <= 1'b1;
      end
    end
  end

  // result payloads
  always_ff @(posedge clk) begin
    if (out_free) begin
      if (skid_valid) begin
        out_reg <= skid_reg;
      end else if (res_valid) begin
        out_reg <= res;
      end
    end
    if (res_valid && !out_free) begin
      skid_reg <= res;
    end
  end

  assign packet_byte     = out_reg.packet_byte;
  assign position        = out_reg.position;
  assign last_of_packet  = out_reg.last_of_packet;
  assign declared_length = out_reg.declared_length;

  // checks
  `SLPD_ASSERT_NOW(a_skid_behind_out, skid_valid, out_valid, "skid full with output empty")
  `SLPD_ASSERT_NOW(a_data_count_live, phase == PHASE_DATA, bytes_left != '0, "data phase with no bytes left")
  `SLPD_ASSERT_NEXT(a_last_ends_packet, res_valid && res.last_of_packet, phase == PHASE_HUNT, "last byte did not return to hunt")
  `SLPD_ASSERT_NEXT(a_count_in_range, accept && phase == PHASE_LEN_LOW, bytes_left <= MAX_LENGTH_CEILING + POS_W'(1), "byte count above clamp")

endmodule
